FILE: rtl/bepl_pkg.sv
package bepl_pkg;

    localparam int ENERGY_W   = 16;
    localparam int SETPOINT_W = 32;
    localparam int FACTOR_W   = 16;
    localparam int FRAC_W     = 15;
    localparam int DIV_W      = 19;
    localparam int SEG_W      = 3;
    localparam int DELTA_W    = 4;
    localparam int DY_W       = 14;
    localparam int NUM_W      = DELTA_W + DY_W;
    localparam int TDATA_W    = 80;

    localparam logic [FACTOR_W-1:0] FACTOR_ONE = 16'd32768;
    localparam logic [3:0]          DIVISOR    = 4'd10;
    localparam logic [DIV_W-1:0]    ROUND_BIAS = 19'd5;
    localparam logic [SEG_W-1:0]    SEG_SAT    = 3'd7;

    typedef struct packed {
        logic                sat;
        logic [FACTOR_W-1:0] y0;
        logic [DIV_W-1:0]    dividend;
    } bepl_curve_t;

    function automatic logic [5:0] curve_x(input logic [SEG_W-1:0] idx);
        logic [5:0] x;
        unique case (idx)
            3'd0:    x = 6'd0;
            3'd1:    x = 6'd10;
            3'd2:    x = 6'd20;
            3'd3:    x = 6'd30;
            3'd4:    x = 6'd35;
            3'd5:    x = 6'd40;
            3'd6:    x = 6'd50;
            default: x = 6'd60;
        endcase
        return x;
    endfunction

    function automatic logic [FACTOR_W-1:0] curve_y(input logic [SEG_W-1:0] idx);
        logic [FACTOR_W-1:0] y;
        unique case (idx)
            3'd0:    y = 16'd1638;
            3'd1:    y = 16'd4096;
            3'd2:    y = 16'd8192;
            3'd3:    y = 16'd16384;
            3'd4:    y = 16'd24576;
            3'd5:    y = 16'd29491;
            3'd6:    y = 16'd31130;
            default: y = 16'd32768;
        endcase
        return y;
    endfunction

    function automatic logic [DY_W-1:0] curve_dy(input logic [SEG_W-1:0] idx);
        logic [DY_W-1:0] dy;
        unique case (idx)
            3'd0:    dy = 14'd2458;
            3'd1:    dy = 14'd4096;
            3'd2:    dy = 14'd8192;
            3'd3:    dy = 14'd8192;
            3'd4:    dy = 14'd4915;
            3'd5:    dy = 14'd1639;
            3'd6:    dy = 14'd1638;
            default: dy = 14'd0;
        endcase
        return dy;
    endfunction

    function automatic logic curve_short(input logic [SEG_W-1:0] idx);
        return (idx == 3'd3) || (idx == 3'd4);
    endfunction

endpackage

FILE: rtl/bepl_curve.sv
module bepl_curve import bepl_pkg::*;
(
    input  logic [ENERGY_W-1:0] energy,
    output bepl_curve_t         curve
);

    logic [SEG_W-1:0]   seg;
    logic [5:0]         offset;
    logic [DELTA_W-1:0] delta;
    logic [NUM_W-1:0]   num;

    always_comb
    begin
        seg = '0;
        for (int i = 1; i < 8; i++)
        begin
            if (energy >= {{(ENERGY_W-6){1'b0}}, curve_x(SEG_W'(i))})
            begin
                seg = SEG_W'(i);
            end
        end
    end

    assign offset = energy[5:0] - curve_x(seg);
    assign delta  = offset[DELTA_W-1:0];
    assign num    = {{(NUM_W-DELTA_W){1'b0}}, delta} * {{(NUM_W-DY_W){1'b0}}, curve_dy(seg)};

    always_comb
    begin
        curve.sat = (seg == SEG_SAT);
        curve.y0  = curve_y(seg);
        if (curve_short(seg))
        begin
            curve.dividend = {num, 1'b0} + ROUND_BIAS;
        end
        else
        begin
            curve.dividend = {1'b0, num} + ROUND_BIAS;
        end
    end

endmodule

FILE: rtl/bepl_div10.sv
module bepl_div10 import bepl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DIV_W-1:0] num_reg, num_next;
    logic [3:0]       rem_reg, rem_next;
    logic [4:0]       trial;
    logic [4:0]       diff;
    logic             ge;

    assign trial = {rem_reg, num_reg[DIV_W-1]};
    assign ge    = (trial >= {1'b0, DIVISOR});
    assign diff  = trial - {1'b0, DIVISOR};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        num_next  = num_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            cnt_next = CNT_W'(DIV_W);
            num_next = dividend;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
            num_next  = {num_reg[DIV_W-2:0], ge};
            rem_next  = ge ? diff[3:0] : trial[3:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

FILE: rtl/bepl_scale_lane.sv
module bepl_scale_lane import bepl_pkg::*;
(
    input  logic                  clk,
    input  logic                  clear,
    input  logic                  step,
    input  logic                  fbit,
    input  logic [SETPOINT_W-1:0] mcand,
    output logic [SETPOINT_W-1:0] result
);

    logic [SETPOINT_W:0]   hi_reg, hi_next;
    logic [FACTOR_W-1:0]   lo_reg, lo_next;
    logic [SETPOINT_W+1:0] addend;
    logic [SETPOINT_W+1:0] sum;

    assign addend = fbit ? {{2{mcand[SETPOINT_W-1]}}, mcand} : '0;
    assign sum    = {hi_reg[SETPOINT_W], hi_reg} + addend;

    always_comb
    begin
        hi_next = hi_reg;
        lo_next = lo_reg;
        if (clear)
        begin
            hi_next = '0;
            lo_next = '0;
        end
        else if (step)
        begin
            hi_next = sum[SETPOINT_W+1:1];
            lo_next = {sum[0], lo_reg[FACTOR_W-1:1]};
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    // round half up: drop fraction bits, add the first dropped bit
    assign result = {hi_reg[SETPOINT_W-2:0], lo_reg[FACTOR_W-1]}
                  + {{(SETPOINT_W-1){1'b0}}, lo_reg[FACTOR_W-2]};

endmodule

FILE: rtl/buffer_energy_power_limiter_top.sv
// Buffer-energy power limiter.
// Input stream (s_tvalid/s_tready/s_tdata) carries one word per control tick:
// buffer energy in joules, speed and yaw-rate setpoints in signed Q16.16.
// Output stream (m_tvalid/m_tready/m_tdata) returns one word per input word:
// both setpoints scaled by the smoothed limit factor, and the factor in Q1.15.
// The energy maps through a fixed piecewise-linear curve to a target factor,
// which a first-order filter (0.9 old + 0.1 target) smooths.
// Per item, a shared bit-serial divide-by-ten unit runs once for the curve
// (skipped when the energy is 60 J or more) and once for the filter, then two
// shift-add lanes scale both setpoints at one factor bit per cycle.
// s_tready is high only while no word is in work.
// A finished word sits in an output register; the next input word is taken
// while it waits, and its result waits for the register while m_tready is low.
// Reset sets the smoothed factor to one and empties the output register.
module buffer_energy_power_limiter_top import bepl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,  // energy, speed_setpoint, yaw_rate_setpoint
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata   // scaled_speed, scaled_yaw_rate, limit_factor
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CURVE,
        ST_CURVE_WAIT,
        ST_FILT_START,
        ST_FILT_WAIT,
        ST_SCALE,
        ST_LOAD
    } state_t;

    state_t                state_reg, state_next;
    logic [ENERGY_W-1:0]   energy_reg, energy_next;
    logic [SETPOINT_W-1:0] speed_reg, speed_next;
    logic [SETPOINT_W-1:0] yaw_reg, yaw_next;
    logic [FACTOR_W-1:0]   target_reg, target_next;
    logic [FACTOR_W-1:0]   factor_reg, factor_next;
    logic [FACTOR_W-1:0]   fsh_reg, fsh_next;
    logic [3:0]            cnt_reg, cnt_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0]    m_tdata_reg, m_tdata_next;

    bepl_curve_t           curve;
    logic                  div_start;
    logic [DIV_W-1:0]      div_dividend;
    logic                  div_done;
    logic [DIV_W-1:0]      div_quot;
    logic [FACTOR_W-1:0]   factor_new;
    logic                  lane_clear;
    logic                  lane_step;
    logic [SETPOINT_W-1:0] speed_res;
    logic [SETPOINT_W-1:0] yaw_res;

    bepl_curve u_curve
    (
        .energy (energy_reg),
        .curve  (curve)
    );

    bepl_div10 u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .done     (div_done),
        .quotient (div_quot)
    );

    bepl_scale_lane u_speed
    (
        .clk    (clk),
        .clear  (lane_clear),
        .step   (lane_step),
        .fbit   (fsh_reg[0]),
        .mcand  (speed_reg),
        .result (speed_res)
    );

    bepl_scale_lane u_yaw
    (
        .clk    (clk),
        .clear  (lane_clear),
        .step   (lane_step),
        .fbit   (fsh_reg[0]),
        .mcand  (yaw_reg),
        .result (yaw_res)
    );

    assign div_start    = ((state_reg == ST_CURVE) && !curve.sat) || (state_reg == ST_FILT_START);
    assign div_dividend = (state_reg == ST_CURVE) ? curve.dividend
                        : {factor_reg, 3'b000} + {3'b000, factor_reg}
                          + {3'b000, target_reg} + ROUND_BIAS;
    assign factor_new   = (div_quot > {3'b000, FACTOR_ONE}) ? FACTOR_ONE : div_quot[FACTOR_W-1:0];
    assign lane_clear   = (state_reg == ST_FILT_WAIT) && div_done;
    assign lane_step    = (state_reg == ST_SCALE);

    always_comb
    begin
        state_next    = state_reg;
        energy_next   = energy_reg;
        speed_next    = speed_reg;
        yaw_next      = yaw_reg;
        target_next   = target_reg;
        factor_next   = factor_reg;
        fsh_next      = fsh_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    energy_next = s_tdata[ENERGY_W-1:0];
                    speed_next  = s_tdata[ENERGY_W +: SETPOINT_W];
                    yaw_next    = s_tdata[ENERGY_W+SETPOINT_W +: SETPOINT_W];
                    state_next  = ST_CURVE;
                end
            end
            ST_CURVE:
            begin
                if (curve.sat)
                begin
                    target_next = FACTOR_ONE;
                    state_next  = ST_FILT_START;
                end
                else
                begin
                    state_next = ST_CURVE_WAIT;
                end
            end
            ST_CURVE_WAIT:
            begin
                if (div_done)
                begin
                    target_next = curve.y0 + div_quot[FACTOR_W-1:0];
                    state_next  = ST_FILT_START;
                end
            end
            ST_FILT_START:
            begin
                state_next = ST_FILT_WAIT;
            end
            ST_FILT_WAIT:
            begin
                if (div_done)
                begin
                    factor_next = factor_new;
                    fsh_next    = factor_new;
                    cnt_next    = '0;
                    state_next  = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                fsh_next = {1'b0, fsh_reg[FACTOR_W-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 4'(FACTOR_W - 1))
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {factor_reg, yaw_res, speed_res};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            factor_reg   <= FACTOR_ONE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            factor_reg   <= factor_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    always_ff @(posedge clk)
    begin
        energy_reg  <= energy_next;
        speed_reg   <= speed_next;
        yaw_reg     <= yaw_next;
        target_reg  <= target_next;
        fsh_reg     <= fsh_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
